/* hw/rtl/vcl_pkg.sv */
// Package for the vector circle limiter: data width constants, payload structs
// and the register address map. No dependencies.
package vcl_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = DATA_WIDTH - 1;
    localparam int ADDR_WIDTH = 3;

    localparam logic [FRAC_BITS-1:0]  FULL_SCALE = {FRAC_BITS{1'b1}};
    localparam logic [ADDR_WIDTH-1:0] ADDR_MAGNITUDE_LIMIT = 3'd0;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x_in;
        logic signed [DATA_WIDTH-1:0] y_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x_out;
        logic signed [DATA_WIDTH-1:0] y_out;
        logic        [FRAC_BITS-1:0]  scale_factor;
        logic                         was_limited;
    } t_out;

    // Fields that ride along the whole pipeline with each vector.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic        [FRAC_BITS-1:0]  lim;
        logic                         gt;
    } t_carry;

endpackage

/* hw/rtl/vector_circle_limit_q15_unit.sv */
// Top level of the vector circle limiter: fully pipelined square, compare,
// square root, division and scaling. Depends on vcl_pkg.
//
// Usage:
//   Input channel (i_valid/o_ready, i_data) transfers one signed Q15 vector
//   per cycle while o_ready is high. Output channel (o_valid/i_ready, o_data)
//   transfers the limited vector, the Q15 scale factor and a limited flag,
//   one per input, in order.
//   The magnitude limit register sits at APB byte address 0; write it only
//   while the pipeline is empty. pready is tied high, reads return the limit.
//   Pipeline stages: input register, two squaring/compare stages, one stage
//   per root bit of the bit-serial square root (16), one stage per quotient
//   bit of the restoring divider (16), clamp, multiply and output register.
//   Throughput is one transfer per cycle on both sides while the receiver
//   does not stall.
//   Reset clears all valid bits and sets the limit to full scale (32767).
//   When the receiver stalls, the whole pipeline holds; o_ready stays high
//   as long as the output register is empty or being drained, so nothing is
//   lost or repeated.
module vector_circle_limit_q15_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  vcl_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output vcl_pkg::t_out                 o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcl_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import vcl_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SQ0 = 3;           // first square root step stage
    localparam int DV0 = SQ0 + W;     // first divider step stage
    localparam int CLP = DV0 + F + 1; // clamp stage
    localparam int MUL = CLP + 1;     // product stage
    localparam int NS  = MUL + 2;     // stage count, output register last

    logic en;
    logic [NS-1:0] r_vld;
    t_carry r_c [NS];

    logic [F-1:0] r_limit;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAGNITUDE_LIMIT) ? {{(32-F){1'b0}}, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= FULL_SCALE;
        end else if (psel && penable && pwrite && paddr == ADDR_MAGNITUDE_LIMIT) begin
            r_limit <= pwdata[F-1:0];
        end
    end

    // Global advance: move everything when the output register frees up.
    assign en      = !r_vld[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // Squares and limit squared
    logic [2*W-1:0] r_xx, r_yy, r_ll;
    logic [2*W-1:0] n_sum;
    assign n_sum = r_xx + r_yy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[0] <= '{x: i_data.x_in, y: i_data.y_in, lim: r_limit, gt: 1'b0};
            r_xx   <= (2*W)'($signed(r_c[0].x) * $signed(r_c[0].x));
            r_yy   <= (2*W)'($signed(r_c[0].y) * $signed(r_c[0].y));
            r_ll   <= (2*W)'(r_c[0].lim * r_c[0].lim);
            r_c[1] <= r_c[0];
            r_c[2] <= '{x: r_c[1].x, y: r_c[1].y, lim: r_c[1].lim, gt: n_sum > r_ll};
            for (int i = 3; i < NS; i++) begin
                r_c[i] <= r_c[i-1];
            end
        end
    end

    // Bit-serial square root: one root bit per stage.
    logic [2*W-1:0] r_rad  [W+1];
    logic [W+1:0]   r_srem [W+1];
    logic [W-1:0]   r_root [W+1];
    logic [2*W-1:0] n_rad  [W];
    logic [W+1:0]   n_srem [W];
    logic [W-1:0]   n_root [W];

    always_comb begin
        for (int k = 0; k < W; k++) begin
            logic [W+3:0] remc;
            logic [W+3:0] t;
            remc = {r_srem[k], r_rad[k][2*W-1 -: 2]};
            t    = {2'b00, r_root[k], 2'b01};
            n_rad[k] = {r_rad[k][2*W-3:0], 2'b00};
            if (remc >= t) begin
                n_srem[k] = (W+2)'(remc - t);
                n_root[k] = {r_root[k][W-2:0], 1'b1};
            end else begin
                n_srem[k] = remc[W+1:0];
                n_root[k] = {r_root[k][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad[0]  <= n_sum;
            r_srem[0] <= '0;
            r_root[0] <= '0;
            for (int k = 0; k < W; k++) begin
                r_rad[k+1]  <= n_rad[k];
                r_srem[k+1] <= n_srem[k];
                r_root[k+1] <= n_root[k];
            end
        end
    end

    // Restoring divider: (lim << F) / mag, one quotient bit per stage.
    // Since mag >= lim whenever the result is used, F+1 bits suffice.
    logic [W:0]   r_drem [F+1];
    logic [F:0]   r_q    [F+1];
    logic [W-1:0] r_mag  [F+1];
    logic [W:0]   n_drem [F+1];
    logic [F:0]   n_q    [F+1];

    always_comb begin
        for (int k = 0; k <= F; k++) begin
            logic [W:0]   prem;
            logic [F:0]   pq;
            logic [W-1:0] pmag;
            logic [W+1:0] sh;
            if (k == 0) begin
                prem = (W+1)'(r_c[DV0-1].lim >> 1);
                pq   = '0;
                pmag = r_root[W];
                sh   = {prem, r_c[DV0-1].lim[0]};
            end else begin
                prem = r_drem[k-1];
                pq   = r_q[k-1];
                pmag = r_mag[k-1];
                sh   = {prem, 1'b0};
            end
            if (sh >= {2'b00, pmag}) begin
                n_drem[k] = (W+1)'(sh - {2'b00, pmag});
                n_q[k]    = {pq[F-1:0], 1'b1};
            end else begin
                n_drem[k] = sh[W:0];
                n_q[k]    = {pq[F-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag[0] <= r_root[W];
            for (int k = 0; k <= F; k++) begin
                r_drem[k] <= n_drem[k];
                r_q[k]    <= n_q[k];
            end
            for (int k = 1; k <= F; k++) begin
                r_mag[k] <= r_mag[k-1];
            end
        end
    end

    // Clamp, multiply, shift
    logic [F-1:0] r_scale, r_scale_m;
    logic         r_limf, r_limf_m;
    logic [F-1:0] n_scale;
    logic signed [2*W-1:0] r_px, r_py;

    always_comb begin
        n_scale = FULL_SCALE;
        if (r_c[CLP-1].gt && r_q[F] < {1'b0, FULL_SCALE}) begin
            n_scale = r_q[F][F-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scale   <= n_scale;
            r_limf    <= n_scale != FULL_SCALE;
            r_px      <= (2*W)'($signed(r_c[CLP].x) * $signed({1'b0, r_scale}));
            r_py      <= (2*W)'($signed(r_c[CLP].y) * $signed({1'b0, r_scale}));
            r_scale_m <= r_scale;
            r_limf_m  <= r_limf;
            o_data.scale_factor <= r_scale_m;
            o_data.was_limited  <= r_limf_m;
            if (r_limf_m) begin
                o_data.x_out <= W'(r_px >>> F);
                o_data.y_out <= W'(r_py >>> F);
            end else begin
                o_data.x_out <= r_c[MUL].x;
                o_data.y_out <= r_c[MUL].y;
            end
        end
    end

endmodule
